// ===== hw/rtl/msb_pkg.sv =====
// Package for the masked shift blitter: word width, register indexes,
// configuration reset values and default row length. No dependencies.
`default_nettype none

package msb_pkg;

   localparam int WORD_BITS         = 32;
   localparam int SHIFT_BITS        = 5;
   localparam int ROW_BITS          = 13;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int MAX_ROW_WORDS_DEF = 4096;

   typedef logic [WORD_BITS-1:0]      word_type;
   typedef logic [SHIFT_BITS-1:0]     shift_type;
   typedef logic [ROW_BITS-1:0]       row_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register indexes
   localparam csr_index_type REG_SRC_SHIFT  = 3'd0;
   localparam csr_index_type REG_MASK_SHIFT = 3'd1;
   localparam csr_index_type REG_MODE       = 3'd2;
   localparam csr_index_type REG_FIRST_MASK = 3'd3;
   localparam csr_index_type REG_LAST_MASK  = 3'd4;
   localparam csr_index_type REG_ROW_WORDS  = 3'd5;
   localparam csr_index_type REG_DROP_FIRST = 3'd6;

   // Mode codes: copy source (minterm f0) or select by mask (minterm e2)
   localparam logic MODE_COPY   = 1'b0;
   localparam logic MODE_SELECT = 1'b1;

   localparam word_type EDGE_MASK_RESET = {WORD_BITS{1'b1}};
   localparam row_type  ROW_WORDS_RESET = 13'd1;

endpackage : msb_pkg

`default_nettype wire

// ===== hw/rtl/masked_shift_blitter_unit.sv =====
// Masked shift blitter datapath: funnel shift, minterm select and edge merge.
// Depends on msb_pkg.
`default_nettype none

// One result beat for every request beat, in order. A request is registered,
// then shifted, combined and edge-merged in one pass into the result register,
// so a beat is accepted every cycle while the output does not stall; the
// shift carries and the column counter advance as each beat leaves the input
// register. The result register lets a new request in while a result waits.
// Configuration writes are always taken, must only be made while the block is
// empty, and a write to a known index restarts the row (carries and column cleared).
module masked_shift_blitter_unit
   import msb_pkg::*;
#(
   parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [WORD_BITS-1:0]      req_src_word,
   input  wire logic [WORD_BITS-1:0]      req_mask_word,
   input  wire logic [WORD_BITS-1:0]      req_back_word,
   input  wire logic [WORD_BITS-1:0]      req_dest_word,

   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [WORD_BITS-1:0]      rsp_out_word,
   output      logic                      rsp_write_valid,
   output      logic                      rsp_row_end,

   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0]      csr_wdata
);

   localparam int CNT_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
   localparam int LEN_W = (CNT_W + 1 > ROW_BITS) ? CNT_W + 1 : ROW_BITS;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_WORDS);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

   // Configuration
   shift_type src_shift_ff,  src_shift_in;
   shift_type mask_shift_ff, mask_shift_in;
   logic      mode_ff,       mode_in;
   word_type  first_mask_ff, first_mask_in;
   word_type  last_mask_ff,  last_mask_in;
   row_type   row_words_ff,  row_words_in;
   logic      drop_first_ff, drop_first_in;

   // Row state
   word_type           src_carry_ff,  src_carry_in;
   word_type           mask_carry_ff, mask_carry_in;
   logic [CNT_W-1:0]   column_ff,     column_in;
   logic               preload_ff,    preload_in;

   // Input register
   logic     in_valid_ff, in_valid_in;
   word_type in_src_ff,  in_mask_ff, in_back_ff, in_dest_ff;

   // Result register
   logic     out_valid_ff, out_valid_in;
   word_type out_word_ff,  out_word_in;
   logic     out_wr_ff,    out_wr_in;
   logic     out_end_ff,   out_end_in;

   logic             req_take;
   logic             out_free;
   logic             move;
   logic             csr_write;
   logic             known_reg;
   word_type         src_sh;
   word_type         mask_sh;
   word_type         res_mix;
   word_type         res_first;
   word_type         res_last;
   logic [LEN_W-1:0] len_raw;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] column_next;
   logic             last_word;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;

   always_comb begin
      // Funnel shift: carry word above the current word, shifted right
      src_sh  = word_type'({src_carry_ff, in_src_ff} >> src_shift_ff);
      mask_sh = word_type'({mask_carry_ff, in_mask_ff} >> mask_shift_ff);

      if (mode_ff == MODE_SELECT) begin
         res_mix = (src_sh & mask_sh) | (in_back_ff & ~mask_sh);
      end else begin
         res_mix = src_sh;
      end

      if (column_ff == '0) begin
         res_first = (res_mix & first_mask_ff) | (in_dest_ff & ~first_mask_ff);
      end else begin
         res_first = res_mix;
      end
      res_last = (res_first & last_mask_ff) | (in_dest_ff & ~last_mask_ff);

      // Row length: zero reads as one, clamped to the counter range
      len_raw = LEN_W'(row_words_ff);
      if (len_raw == '0) begin
         len = LEN_ONE;
      end else if (len_raw > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = len_raw;
      end
      column_next = LEN_W'(column_ff) + LEN_ONE;
      last_word   = column_next >= len;
   end

   always_comb begin
      src_shift_in  = src_shift_ff;
      mask_shift_in = mask_shift_ff;
      mode_in       = mode_ff;
      first_mask_in = first_mask_ff;
      last_mask_in  = last_mask_ff;
      row_words_in  = row_words_ff;
      drop_first_in = drop_first_ff;
      known_reg     = 1'b1;
      if (csr_write) begin
         case (csr_index)
            REG_SRC_SHIFT:  src_shift_in  = csr_wdata[SHIFT_BITS-1:0];
            REG_MASK_SHIFT: mask_shift_in = csr_wdata[SHIFT_BITS-1:0];
            REG_MODE:       mode_in       = csr_wdata[0];
            REG_FIRST_MASK: first_mask_in = csr_wdata;
            REG_LAST_MASK:  last_mask_in  = csr_wdata;
            REG_ROW_WORDS:  row_words_in  = csr_wdata[ROW_BITS-1:0];
            REG_DROP_FIRST: drop_first_in = csr_wdata[0];
            default:        known_reg     = 1'b0;
         endcase
      end
   end

   always_comb begin
      src_carry_in  = src_carry_ff;
      mask_carry_in = mask_carry_ff;
      column_in     = column_ff;
      preload_in    = preload_ff;
      out_word_in   = out_word_ff;
      out_wr_in     = out_wr_ff;
      out_end_in    = out_end_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      in_valid_in   = req_take || (in_valid_ff && !out_free);

      if (move) begin
         out_valid_in  = 1'b1;
         src_carry_in  = in_src_ff;
         mask_carry_in = in_mask_ff;
         if (preload_ff) begin
            // preload beat: the carries load and a non-writing result beat goes out
            preload_in  = 1'b0;
            out_word_in = '0;
            out_wr_in   = 1'b0;
            out_end_in  = 1'b0;
         end else if (last_word) begin
            out_word_in   = res_last;
            out_wr_in     = 1'b1;
            out_end_in    = 1'b1;
            column_in     = '0;
            src_carry_in  = '0;
            mask_carry_in = '0;
            preload_in    = drop_first_ff;
         end else begin
            out_word_in = res_first;
            out_wr_in   = 1'b1;
            out_end_in  = 1'b0;
            column_in   = CNT_W'(column_next);
         end
      end

      if (csr_write && known_reg) begin
         column_in     = '0;
         src_carry_in  = '0;
         mask_carry_in = '0;
         preload_in    = drop_first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_shift_ff  <= '0;
         mask_shift_ff <= '0;
         mode_ff       <= MODE_COPY;
         first_mask_ff <= EDGE_MASK_RESET;
         last_mask_ff  <= EDGE_MASK_RESET;
         row_words_ff  <= ROW_WORDS_RESET;
         drop_first_ff <= 1'b0;
         src_carry_ff  <= '0;
         mask_carry_ff <= '0;
         column_ff     <= '0;
         preload_ff    <= 1'b0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         src_shift_ff  <= src_shift_in;
         mask_shift_ff <= mask_shift_in;
         mode_ff       <= mode_in;
         first_mask_ff <= first_mask_in;
         last_mask_ff  <= last_mask_in;
         row_words_ff  <= row_words_in;
         drop_first_ff <= drop_first_in;
         src_carry_ff  <= src_carry_in;
         mask_carry_ff <= mask_carry_in;
         column_ff     <= column_in;
         preload_ff    <= preload_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_src_ff  <= req_src_word;
         in_mask_ff <= req_mask_word;
         in_back_ff <= req_back_word;
         in_dest_ff <= req_dest_word;
      end
      out_word_ff <= out_word_in;
      out_wr_ff   <= out_wr_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_word    = out_word_ff;
   assign rsp_write_valid = out_wr_ff;
   assign rsp_row_end     = out_end_ff;

endmodule : masked_shift_blitter_unit

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for masked_shift_blitter_unit: directed table, then random
// rows; each result beat is checked against a typed table entry or a local datapath model.
// Depends on msb_pkg and the masked_shift_blitter_unit RTL.
module testbench
   import msb_pkg::*;
;

   localparam csr_index_type REG_UNUSED = 3'd7;

   typedef struct packed {
      word_type out_word;
      logic     write_valid;
      logic     row_end;
   } blit_result_type;

   typedef struct {
      logic            is_write;
      csr_index_type   index;
      word_type        wdata;
      word_type        src;
      word_type        mask;
      word_type        back;
      word_type        dest;
      logic            typed;
      blit_result_type result;
   } directed_step_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   word_type      req_src_word = '0;
   word_type      req_mask_word = '0;
   word_type      req_back_word = '0;
   word_type      req_dest_word = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   word_type      rsp_out_word;
   logic          rsp_write_valid;
   logic          rsp_row_end;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_SRC_SHIFT;
   word_type      csr_wdata = '0;

   // Model copy of the registers and the row state
   shift_type   cfg_src_shift = '0;
   shift_type   cfg_mask_shift = '0;
   logic        cfg_mode = MODE_COPY;
   word_type    cfg_first_mask = EDGE_MASK_RESET;
   word_type    cfg_last_mask = EDGE_MASK_RESET;
   row_type     cfg_row_words = ROW_WORDS_RESET;
   logic        cfg_drop_first = 1'b0;
   word_type    src_carry = '0;
   word_type    mask_carry = '0;
   int unsigned column = 0;
   logic        preload_pending = 1'b0;

   blit_result_type   pending_words[$];
   directed_step_type directed_steps[$];
   int unsigned       mismatch_count = 0;
   logic              quiet = 1'b0;

   masked_shift_blitter_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_word    (req_src_word),
      .req_mask_word   (req_mask_word),
      .req_back_word   (req_back_word),
      .req_dest_word   (req_dest_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_word    (rsp_out_word),
      .rsp_write_valid (rsp_write_valid),
      .rsp_row_end     (rsp_row_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic word_type funnel_right(word_type cur, word_type carry, shift_type amt);
      if (amt == 0) return cur;
      return (cur >> amt) | (carry << (WORD_BITS - amt));
   endfunction

   function automatic int unsigned row_length();
      if (cfg_row_words == 0) return 1;
      if (cfg_row_words > MAX_ROW_WORDS_DEF) return MAX_ROW_WORDS_DEF;
      return cfg_row_words;
   endfunction

   function automatic void restart_row();
      column = 0;
      src_carry = '0;
      mask_carry = '0;
      preload_pending = cfg_drop_first;
   endfunction

   function automatic void apply_reg(csr_index_type idx, word_type data);
      case (idx)
         REG_SRC_SHIFT:  cfg_src_shift = data[SHIFT_BITS-1:0];
         REG_MASK_SHIFT: cfg_mask_shift = data[SHIFT_BITS-1:0];
         REG_MODE:       cfg_mode = data[0];
         REG_FIRST_MASK: cfg_first_mask = data;
         REG_LAST_MASK:  cfg_last_mask = data;
         REG_ROW_WORDS:  cfg_row_words = data[ROW_BITS-1:0];
         REG_DROP_FIRST: cfg_drop_first = data[0];
         default:        return;
      endcase
      restart_row();
   endfunction

   function automatic blit_result_type blit_word(word_type src, word_type mask,
                                                 word_type back, word_type dest);
      word_type        shifted_src;
      word_type        shifted_mask;
      word_type        composed;
      blit_result_type res;
      shifted_src = funnel_right(src, src_carry, cfg_src_shift);
      shifted_mask = funnel_right(mask, mask_carry, cfg_mask_shift);
      src_carry = src;
      mask_carry = mask;
      res = '0;
      if (preload_pending) begin
         preload_pending = 1'b0;
         return res;
      end
      if (cfg_mode == MODE_COPY)
         composed = shifted_src;
      else
         composed = (shifted_src & shifted_mask) | (back & ~shifted_mask);
      if (column == 0)
         composed = (composed & cfg_first_mask) | (dest & ~cfg_first_mask);
      if (column + 1 >= row_length()) begin
         composed = (composed & cfg_last_mask) | (dest & ~cfg_last_mask);
         res.row_end = 1'b1;
         restart_row();
      end else begin
         column++;
      end
      res.out_word = composed;
      res.write_valid = 1'b1;
      return res;
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return EDGE_MASK_RESET;
         2:       return word_type'(1) << $urandom_range(0, WORD_BITS - 1);
         3:       return ~(word_type'(1) << $urandom_range(0, WORD_BITS - 1));
         default: return $urandom;
      endcase
   endfunction

   function automatic word_type pick_mask();
      case ($urandom_range(0, 5))
         0:       return EDGE_MASK_RESET;
         1:       return '0;
         2:       return EDGE_MASK_RESET >> $urandom_range(0, WORD_BITS - 1);
         3:       return EDGE_MASK_RESET << $urandom_range(0, WORD_BITS - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic word_type pick_reg_value(csr_index_type idx);
      word_type v;
      case (idx)
         REG_SRC_SHIFT, REG_MASK_SHIFT: begin
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = 31;
               2:       v = $urandom;
               default: v = $urandom_range(1, 30);
            endcase
         end
         REG_FIRST_MASK, REG_LAST_MASK: v = pick_mask();
         REG_ROW_WORDS: begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            // junk above the field must be ignored
            if ($urandom_range(0, 3) == 0) v = v | ($urandom & 32'hffff_e000);
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic void add_write(csr_index_type idx, word_type data);
      directed_step_type st;
      st = '{default: '0};
      st.is_write = 1'b1;
      st.index = idx;
      st.wdata = data;
      directed_steps.push_back(st);
   endfunction

   function automatic void add_item(word_type src, word_type mask, word_type back,
                                    word_type dest, logic typed = 1'b0,
                                    blit_result_type result = '0);
      directed_step_type st;
      st = '{default: '0};
      st.src = src;
      st.mask = mask;
      st.back = back;
      st.dest = dest;
      st.typed = typed;
      st.result = result;
      directed_steps.push_back(st);
   endfunction

   // One register beat, then the port goes idle again.
   task automatic write_reg(csr_index_type idx, word_type data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_item(word_type src, word_type mask, word_type back, word_type dest,
                            logic typed = 1'b0, blit_result_type result = '0);
      int              gap;
      blit_result_type predicted;
      gap = draw_gap();
      csr_valid = 1'b0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_src_word = src;
      req_mask_word = mask;
      req_back_word = back;
      req_dest_word = dest;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = blit_word(src, mask, back, dest);
      pending_words.push_back(typed ? result : predicted);
      @(negedge clock);
   endtask

   // Block must be empty before a register write
   task automatic settle_block();
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_random_items(int unsigned count);
      repeat (count) send_item(pick_word(), pick_word(), pick_word(), pick_word());
   endtask

   task automatic check_result();
      blit_result_type exp;
      if (pending_words.size() == 0) begin
         $error("result beat with no expectation: out_word %h", rsp_out_word);
         mismatch_count++;
      end else begin
         exp = pending_words.pop_front();
         if (rsp_out_word !== exp.out_word) begin
            $error("out_word: expected %h, got %h", exp.out_word, rsp_out_word);
            mismatch_count++;
         end
         if (rsp_write_valid !== exp.write_valid) begin
            $error("write_valid: expected %b, got %b", exp.write_valid, rsp_write_valid);
            mismatch_count++;
         end
         if (rsp_row_end !== exp.row_end) begin
            $error("row_end: expected %b, got %b", exp.row_end, rsp_row_end);
            mismatch_count++;
         end
      end
   endtask

   initial begin : result_sink
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_result();
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned       items_sent;
      int unsigned       len;
      int unsigned       count;
      int                i;
      directed_step_type st;

      // After reset: copy mode, full edge masks, one-word rows
      add_item(32'hffff_ffff, 32'h0, 32'h0, 32'h0, 1'b1, '{32'hffff_ffff, 1'b1, 1'b1});
      add_item(32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b1});
      add_write(REG_MODE, word_type'(MODE_SELECT));
      add_item(32'hffff_ffff, 32'h0000_ffff, 32'haaaa_aaaa, 32'h0, 1'b1,
               '{32'haaaa_ffff, 1'b1, 1'b1});
      // empty first mask: the word is all old destination
      add_write(REG_FIRST_MASK, 32'h0);
      add_item(32'h1234_5678, 32'hffff_ffff, 32'h0, 32'h5a5a_5a5a, 1'b1,
               '{32'h5a5a_5a5a, 1'b1, 1'b1});
      // single-word row takes both edge masks
      add_write(REG_FIRST_MASK, 32'hffff_0000);
      add_write(REG_LAST_MASK, 32'h00ff_ffff);
      add_item(32'h1111_1111, 32'hffff_ffff, 32'h0, 32'heeee_eeee, 1'b1,
               '{32'hee11_eeee, 1'b1, 1'b1});
      // zero row length behaves as one
      add_write(REG_ROW_WORDS, 32'h0);
      add_item(32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 1'b1, '{32'hff00_ffff, 1'b1, 1'b1});
      // preload rows, widest source shift, junk above each narrow field
      add_write(REG_DROP_FIRST, 32'hffff_ffff);
      add_write(REG_ROW_WORDS, 32'hffff_e002);
      add_write(REG_SRC_SHIFT, 32'hffff_ffff);
      add_write(REG_MASK_SHIFT, 32'h0000_0021);
      add_write(REG_FIRST_MASK, 32'hffff_ffff);
      add_write(REG_LAST_MASK, 32'hffff_ffff);
      add_item(32'h8000_0001, 32'hffff_ffff, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b0});
      add_item(32'h0000_0003, 32'hc000_0000, 32'h5555_5555, 32'h0);
      add_item(32'hffff_fffe, 32'h7fff_ffff, 32'haaaa_aaaa, 32'hffff_ffff);
      add_item(32'hdead_beef, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b0});
      add_item(32'h0123_4567, 32'h8765_4321, 32'hffff_0000, 32'h0f0f_0f0f);
      // unused index: no restart, the row carries on
      add_write(REG_UNUSED, 32'hffff_ffff);
      add_item(32'h8000_0000, 32'h0000_0001, 32'h3333_3333, 32'hcccc_cccc);
      add_write(REG_DROP_FIRST, 32'h0);
      add_write(REG_ROW_WORDS, 32'h3);
      add_write(REG_MODE, word_type'(MODE_COPY));
      add_write(REG_SRC_SHIFT, 32'h4);
      add_write(REG_FIRST_MASK, 32'h0fff_ffff);
      add_write(REG_LAST_MASK, 32'hffff_fff0);
      add_item(32'h89ab_cdef, 32'h0, 32'h0, 32'hffff_ffff);
      add_item(32'h0123_4567, 32'h0, 32'h0, 32'hffff_ffff);
      add_item(32'hfedc_ba98, 32'h0, 32'h0, 32'h0);
      add_write(REG_LAST_MASK, 32'h0);
      add_write(REG_ROW_WORDS, 32'h1);
      add_item(32'h7654_3210, 32'h0, 32'h0, 32'h1357_9bdf, 1'b1, '{32'h1357_9bdf, 1'b1, 1'b1});
      add_write(REG_ROW_WORDS, 32'h2);
      add_write(REG_MODE, word_type'(MODE_SELECT));
      add_write(REG_MASK_SHIFT, 32'd31);
      add_write(REG_SRC_SHIFT, 32'h0);
      add_write(REG_FIRST_MASK, EDGE_MASK_RESET);
      add_write(REG_LAST_MASK, EDGE_MASK_RESET);
      add_item(32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0);
      add_item(32'hffff_ffff, 32'h8000_0000, 32'h0, 32'h0);
      add_item(32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
      add_item(32'hffff_ffff, 32'h0, 32'h0, 32'h0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      restart_row();

      foreach (directed_steps[k]) begin
         st = directed_steps[k];
         if (st.is_write) begin
            settle_block();
            write_reg(st.index, st.wdata);
         end else begin
            send_item(st.src, st.mask, st.back, st.dest, st.typed, st.result);
         end
      end

      // Random phases of whole rows, some cut short by the next write
      items_sent = 0;
      while (items_sent < 1600) begin
         settle_block();
         quiet = ($urandom_range(0, 4) == 0);
         for (i = REG_SRC_SHIFT; i <= REG_UNUSED; i++) begin
            if ($urandom_range(0, 1))
               write_reg(csr_index_type'(i), pick_reg_value(csr_index_type'(i)));
         end
         len = row_length();
         count = (len + cfg_drop_first) * $urandom_range(1, 4);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, len);
         send_random_items(count);
         items_sent += count;
      end

      req_valid = 1'b0;
      csr_valid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
